FILE: sv/crp_pkg.sv
package crp_pkg;

  localparam int unsigned ColorRegs      = 256;
  localparam int unsigned PaletteEntries = 16;

  localparam int unsigned IdxW   = 9;
  localparam int unsigned CompW  = 16;
  localparam int unsigned LenW   = 4;
  localparam int unsigned OffW   = 5;
  localparam int unsigned PixW   = 32;
  localparam int unsigned PalIdxW = 4;
  localparam int unsigned NumComp = 4;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 104;

  // luma weights, sum of weights is 256
  localparam logic [6:0] LumaR = 7'd77;
  localparam logic [7:0] LumaG = 8'd151;
  localparam logic [4:0] LumaB = 5'd28;

  localparam logic [31:0] RoundBias   = 32'h0000_7FFF;
  localparam logic [LenW-1:0] DirectLen = 4'd8;

  localparam logic [5:0] Depth16 = 6'd16;
  localparam logic [5:0] Depth24 = 6'd24;
  localparam logic [5:0] Depth32 = 6'd32;

  typedef enum logic [1:0] {
    VisTrue   = 2'd0,
    VisPseudo = 2'd1,
    VisDirect = 2'd2,
    VisOther  = 2'd3
  } visual_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGrayMode = 3'd0,
    CfgVisual   = 3'd1,
    CfgDepth    = 3'd2,
    CfgLengths  = 3'd3,
    CfgOffsets  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                valid;
    logic                reject;
    logic [PalIdxW-1:0]  pal_idx;
  } stage_ctl_t;

endpackage

FILE: sv/crp_round.sv
module crp_round (
  input  logic [crp_pkg::CompW-1:0] comp_i,
  input  logic [crp_pkg::LenW-1:0]  len_i,
  input  crp_pkg::visual_e          visual_i,
  output logic [crp_pkg::CompW-1:0] comp_o
);
  import crp_pkg::*;

  logic [LenW-1:0] width;
  logic [31:0]     scaled;

  always_comb begin
    case (visual_i)
      VisTrue, VisPseudo: width = len_i;
      VisDirect:          width = DirectLen;
      default:            width = len_i;
    endcase
  end

  // ((v << w) + 0x7FFF - v) >> 16, never negative
  assign scaled = (32'(comp_i) << width) + RoundBias - 32'(comp_i);

  always_comb begin
    case (visual_i)
      VisTrue, VisPseudo, VisDirect: comp_o = scaled[31:16];
      default:                       comp_o = comp_i;
    endcase
  end

endmodule

FILE: sv/color_register_pack_top.sv
// Colour register conversion and palette word packing.
// An accepted input transaction goes through the stage 1, 2 and 3 registers and the output register to m_axis.
// Throughput: one transaction per cycle; every stage advances together and
// holds while the output register is full and m_axis_tready is low.
// Reset (rst_ni low, asynchronous): pipeline empties, configuration returns to
// gray off, pseudocolor, depth 1, lengths 0x111, offsets 0.
module color_register_pack_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [crp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [crp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // reg_index[8:0], red_in[24:9], green_in[40:25], blue_in[56:41], transp_in[72:57]
  input  logic [crp_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status[0], palette_write[1], palette_index[5:2], palette_value[37:6],
  // red_out[53:38], green_out[69:54], blue_out[85:70], transp_out[101:86]
  output logic [crp_pkg::OutDataW-1:0]  m_axis_tdata
);
  import crp_pkg::*;

  logic                gray_q;
  visual_e             visual_q;
  logic [5:0]          depth_q;
  logic [15:0]         lengths_q;
  logic [19:0]         offsets_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gray_q    <= 1'b0;
      visual_q  <= VisPseudo;
      depth_q   <= 6'd1;
      lengths_q <= 16'd273;
      offsets_q <= 20'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgGrayMode: gray_q    <= cfg_data_i[0];
        CfgVisual:   visual_q  <= visual_e'(cfg_data_i[1:0]);
        CfgDepth:    depth_q   <= cfg_data_i[5:0];
        CfgLengths:  lengths_q <= cfg_data_i[15:0];
        CfgOffsets:  offsets_q <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  logic advance;
  logic out_valid_q;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;

  // stage 1: capture, range checks, luma products
  logic [IdxW-1:0]  in_idx;
  logic [CompW-1:0] in_comp [NumComp];
  logic             in_reject;

  assign in_idx = s_axis_tdata[IdxW-1:0];
  for (genvar i = 0; i < NumComp; i++) begin : g_in
    assign in_comp[i] = s_axis_tdata[IdxW + CompW*i +: CompW];
  end
  assign in_reject = (in_idx >= IdxW'(ColorRegs)) ||
                     ((visual_q == VisTrue) && (in_idx >= IdxW'(PaletteEntries)));

  stage_ctl_t       s1_q, s1_d;
  logic [CompW-1:0] c1_q [NumComp];
  logic [22:0]      pr1_q;
  logic [23:0]      pg1_q;
  logic [20:0]      pb1_q;

  assign s1_d.valid   = s_axis_tvalid;
  assign s1_d.reject  = in_reject;
  assign s1_d.pal_idx = in_idx[PalIdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (advance) begin
      s1_q <= s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      c1_q  <= in_comp;
      pr1_q <= 23'(in_comp[0]) * 23'(LumaR);
      pg1_q <= 24'(in_comp[1]) * 24'(LumaG);
      pb1_q <= 21'(in_comp[2]) * 21'(LumaB);
    end
  end

  // stage 2: luma sum and component select
  logic [23:0]      luma_sum;
  logic [CompW-1:0] c2_d [NumComp];
  logic [CompW-1:0] c2_q [NumComp];
  stage_ctl_t       s2_q;

  assign luma_sum = 24'(pr1_q) + pg1_q + 24'(pb1_q);

  always_comb begin
    c2_d = c1_q;
    if (gray_q) begin
      c2_d[0] = luma_sum[23:8];
      c2_d[1] = luma_sum[23:8];
      c2_d[2] = luma_sum[23:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else if (advance) begin
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      c2_q <= c2_d;
    end
  end

  // stage 3: rounding to hardware widths (the other visual passes components through)
  logic [CompW-1:0] c3_d [NumComp];
  logic [CompW-1:0] c3_q [NumComp];
  stage_ctl_t       s3_q;

  for (genvar i = 0; i < NumComp; i++) begin : g_round
    crp_round u_round (
      .comp_i   (c2_q[i]),
      .len_i    (lengths_q[LenW*i +: LenW]),
      .visual_i (visual_q),
      .comp_o   (c3_d[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else if (advance) begin
      s3_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      c3_q <= c3_d;
    end
  end

  // stage 4: packing into the output register
  logic [PixW-1:0]    packed_word;
  logic               depth_ok;
  logic               status_d, pal_wr_d;
  logic [PalIdxW-1:0] pal_idx_d;
  logic [PixW-1:0]    pal_val_d;
  logic [CompW-1:0]   comp_out_d [NumComp];

  always_comb begin
    packed_word = '0;
    for (int i = 0; i < NumComp; i++) begin
      packed_word = packed_word | (PixW'(c3_q[i]) << offsets_q[OffW*i +: OffW]);
    end
  end

  assign depth_ok = (depth_q == Depth16) || (depth_q == Depth24) || (depth_q == Depth32);

  always_comb begin
    status_d   = s3_q.reject;
    pal_wr_d   = 1'b0;
    pal_idx_d  = '0;
    pal_val_d  = '0;
    comp_out_d = c3_q;
    if (s3_q.reject) begin
      for (int i = 0; i < NumComp; i++) begin
        comp_out_d[i] = '0;
      end
    end else if (visual_q == VisTrue) begin
      pal_val_d = packed_word;
      if (depth_ok) begin
        pal_wr_d  = 1'b1;
        pal_idx_d = s3_q.pal_idx;
      end
    end
  end

  logic               status_q, pal_wr_q;
  logic [PalIdxW-1:0] pal_idx_q;
  logic [PixW-1:0]    pal_val_q;
  logic [CompW-1:0]   comp_out_q [NumComp];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s3_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q   <= status_d;
      pal_wr_q   <= pal_wr_d;
      pal_idx_q  <= pal_idx_d;
      pal_val_q  <= pal_val_d;
      comp_out_q <= comp_out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, comp_out_q[3], comp_out_q[2], comp_out_q[1], comp_out_q[0],
                          pal_val_q, pal_idx_q, pal_wr_q, status_q};

endmodule
